// ===== hw/rtl/block_average_nearest_palette_top_macros.svh =====
// assertion macros for the block average nearest palette design
// used by block_average_nearest_palette_top; expects clk and rst_n in scope
`ifndef BLOCK_AVERAGE_NEAREST_PALETTE_TOP_MACROS_SVH
`define BLOCK_AVERAGE_NEAREST_PALETTE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BANP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("banp assertion failed");

// next-cycle implication
`define BANP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("banp assertion failed");

`else

`define BANP_ASSERT_IMP(label, ante, cons)

`define BANP_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/banp_pkg.sv =====
// shared types and constants for the block average nearest palette design
// no dependencies
package banp_pkg;

    localparam int DEF_PALETTE_DEPTH  = 256;
    localparam int DEF_SEARCH_ENTRIES = 224;
    localparam int DEF_BLOCK_PIXELS   = 9;

    localparam int CHAN_W = 8;
    localparam int SUM_W  = 12;
    localparam int DIST_W = 18;
    localparam int IDX_W  = 8;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  entry_index;
        logic [CHAN_W-1:0] entry_red;
        logic [CHAN_W-1:0] entry_green;
        logic [CHAN_W-1:0] entry_blue;
        logic [IDX_W-1:0]  pixel_value;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  nearest_index;
        logic [DIST_W-1:0] nearest_distance;
    } result_t;

endpackage

// ===== hw/rtl/block_average_nearest_palette_top.sv =====
// palette-indexed box downscaler with nearest palette color search
// depends on banp_pkg and block_average_nearest_palette_top_macros.svh

// A load transaction (cmd 0) writes one RGB entry into the on-chip palette;
// writes with an index past the palette are dropped. A pixel transaction
// (cmd 1) does one palette read, then one add into the channel sums. The
// pixel that completes a block of BLOCK_PIXELS then runs a divide by a
// constant with its correction step, a search over min(SEARCH_ENTRIES,
// PALETTE_DEPTH) entries, a pipeline drain and the posting of the result.
// The search length is set by the single palette read port feeding one
// distance unit that scores one entry per cycle. item_stall is high while
// a pixel transaction is being worked on; a load never raises it. The
// result sits in an output register, so the next block can start while a
// result waits; only posting a new result waits for the old one to go.
// Palette entries read before being written return undefined colors.
`include "block_average_nearest_palette_top_macros.svh"

module block_average_nearest_palette_top #(
    parameter int PALETTE_DEPTH  = banp_pkg::DEF_PALETTE_DEPTH,
    parameter int SEARCH_ENTRIES = banp_pkg::DEF_SEARCH_ENTRIES,
    parameter int BLOCK_PIXELS   = banp_pkg::DEF_BLOCK_PIXELS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  banp_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output banp_pkg::result_t result
);
    import banp_pkg::*;

    // address and counter widths
    localparam int AW    = $clog2(PALETTE_DEPTH);
    localparam int LIMIT = (SEARCH_ENTRIES < PALETTE_DEPTH) ? SEARCH_ENTRIES : PALETTE_DEPTH;
    localparam int KW    = (LIMIT > 1) ? $clog2(LIMIT) : 1;
    localparam int CW    = $clog2(BLOCK_PIXELS + 1);

    // reciprocal divide by block size: one correction step is enough
    // since the sums stay below 2**SUM_W
    localparam int DIV_SHIFT = SUM_W + 1;
    localparam int DIV_RECIP = (1 << DIV_SHIFT) / BLOCK_PIXELS;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ACCUM  = 7'b0000010,
        ST_DIV    = 7'b0000100,
        ST_FIX    = 7'b0001000,
        ST_SEARCH = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    typedef logic [SUM_W-1:0] sum_arr_t [3];

    state_t state_reg, state_next;

    // palette memory, red in the top byte
    logic [3*CHAN_W-1:0] palette_mem [PALETTE_DEPTH];
    logic [3*CHAN_W-1:0] rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;

    logic                pix_oob_reg, pix_oob_next;
    logic [SUM_W-1:0]    sum_reg [3];
    sum_arr_t            sum_next;
    logic [CW-1:0]       count_reg, count_next;

    logic [SUM_W-1:0]    q0_reg [3];
    logic [CHAN_W-1:0]   avg_reg [3];

    // search pipeline: read, score, compare
    logic [KW-1:0]       k_reg, k_next;
    logic                s1_valid_reg;
    logic [KW-1:0]       s1_idx_reg;
    logic                s2_valid_reg;
    logic [KW-1:0]       s2_idx_reg;
    logic [DIST_W-1:0]   dist_reg, dist_calc;
    logic [DIST_W-1:0]   best_dist_reg;
    logic [KW-1:0]       best_idx_reg;

    logic                result_valid_reg, result_valid_next;
    result_t             result_reg;
    logic                accept, emit_fire;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign emit_fire    = (state_reg == ST_EMIT) && (!result_valid_reg || !result_stall);

    // palette port: loads write while idle, the search sweeps the read side
    assign mem_we  = accept && (item.cmd == CMD_LOAD)
                  && ({1'b0, item.entry_index} < 9'(PALETTE_DEPTH));
    assign rd_addr = (state_reg == ST_SEARCH) ? AW'(k_reg) : item.pixel_value[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            palette_mem[item.entry_index[AW-1:0]] <= {item.entry_red, item.entry_green,
                                                      item.entry_blue};
        end
        rd_data_reg <= palette_mem[rd_addr];
    end

    // distance unit, one entry per cycle
    always_comb
    begin
        logic [CHAN_W-1:0]   a, b, d;
        logic [2*CHAN_W-1:0] sq;
        dist_calc = '0;
        for (int c = 0; c < 3; c++)
        begin
            a = rd_data_reg[(2-c)*CHAN_W +: CHAN_W];
            b = avg_reg[c];
            d = (a > b) ? (a - b) : (b - a);
            sq = d * d;
            dist_calc = dist_calc + DIST_W'(sq);
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        pix_oob_next = pix_oob_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.cmd == CMD_PIXEL))
                begin
                    pix_oob_next = ({1'b0, item.pixel_value} >= 9'(PALETTE_DEPTH));
                    state_next   = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (!pix_oob_reg)
                    begin
                        sum_next[c] = sum_reg[c]
                                    + SUM_W'(rd_data_reg[(2-c)*CHAN_W +: CHAN_W]);
                    end
                end
                count_next = count_reg + CW'(1);
                state_next = (count_next == CW'(BLOCK_PIXELS)) ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                k_next     = '0;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (k_reg == KW'(LIMIT - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        sum_next[c] = '0;
                    end
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (emit_fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pix_oob_reg      <= 1'b0;
            count_reg        <= '0;
            k_reg            <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            pix_oob_reg      <= pix_oob_next;
            count_reg        <= count_next;
            k_reg            <= k_next;
            s1_valid_reg     <= (state_reg == ST_SEARCH);
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= result_valid_next;
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= sum_next[c];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        logic [PROD_W-1:0] prod;
        logic [SUM_W-1:0]  rem;
        if (state_reg == ST_DIV)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod = PROD_W'(sum_reg[c]) * PROD_W'(DIV_RECIP);
                q0_reg[c] <= SUM_W'(prod >> DIV_SHIFT);
            end
        end
        if (state_reg == ST_FIX)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rem = sum_reg[c] - SUM_W'(q0_reg[c] * SUM_W'(BLOCK_PIXELS));
                avg_reg[c] <= (rem >= SUM_W'(BLOCK_PIXELS)) ? CHAN_W'(q0_reg[c] + SUM_W'(1))
                                                             : CHAN_W'(q0_reg[c]);
            end
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
        end
        s1_idx_reg <= k_reg;
        s2_idx_reg <= s1_idx_reg;
        dist_reg   <= dist_calc;
        // strict compare keeps the lowest index on ties
        if (s2_valid_reg && (dist_reg < best_dist_reg))
        begin
            best_dist_reg <= dist_reg;
            best_idx_reg  <= s2_idx_reg;
        end
        if (emit_fire)
        begin
            result_reg.nearest_index    <= IDX_W'(best_idx_reg);
            result_reg.nearest_distance <= best_dist_reg;
        end
    end

    // a pixel transaction always goes through the add step
    `BANP_ASSERT_NXT(a_pixel_to_accum, accept && (item.cmd == CMD_PIXEL), state_reg == ST_ACCUM)
    // the block count never rests at a full block
    `BANP_ASSERT_IMP(a_count_below_block, state_reg == ST_IDLE, count_reg < CW'(BLOCK_PIXELS))
    // compare stage only runs during the sweep or its drain
    `BANP_ASSERT_IMP(a_s2_in_search, s2_valid_reg,
        (state_reg == ST_SEARCH) || (state_reg == ST_DRAIN))
    // posted result carries the best distance found
    `BANP_ASSERT_NXT(a_emit_value, emit_fire,
        result_valid && (result.nearest_distance == $past(best_dist_reg)))
    // chosen index lies in the searched range
    `BANP_ASSERT_IMP(a_index_range, result_valid,
        {1'b0, result.nearest_index} < 9'(LIMIT))

endmodule
